// ===== rtl/core/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Types and widths shared by the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int InW    = 20;
  localparam int EdgeW  = InW + 1;
  localparam int ProdW  = 2 * EdgeW;
  localparam int CrossW = ProdW + 1;
  localparam int MagW   = ProdW;
  localparam int LenW   = 6;
  localparam int UW     = 24;
  localparam int SqW    = 2 * UW;
  localparam int RemW   = 52;
  localparam int RootW  = 25;
  localparam int NumW   = 39;
  localparam int QuoW   = 15;
  localparam int OutW   = 16;
  localparam int FracW  = 14;
  localparam int OneQ14 = 16384;

  typedef struct packed {
    logic signed [InW-1:0] a_x;
    logic signed [InW-1:0] a_y;
    logic signed [InW-1:0] a_z;
    logic signed [InW-1:0] b_x;
    logic signed [InW-1:0] b_y;
    logic signed [InW-1:0] b_z;
    logic signed [InW-1:0] c_x;
    logic signed [InW-1:0] c_y;
    logic signed [InW-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } tri_out_t;

  // Word handed along the square root chain.
  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [2:0]             sign;
    logic [2:0][UW-1:0]     u;
    logic [RemW-1:0]        rem;
    logic [RootW-1:0]       root;
  } sqrt_word_t;

  // Word handed along the divider chain.
  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [2:0]             sign;
    logic [RootW-1:0]       root;
    logic [2:0][NumW-1:0]   rem;
    logic [2:0][QuoW-1:0]   quo;
  } div_word_t;

endpackage

// ===== rtl/core/triangle_unit_normal.sv =====
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle given by three Q10.10 vertices.
// ----------------------------------------------------------------------------
// One word on the input channel carries the three vertices of a triangle;
// one word on the output channel carries the Q1.14 unit normal and a flag
// that marks a triangle whose cross product is zero (its normal is zero).
// Both channels use valid and ready.
// A new triangle is taken every cycle while the receiver does not stall.
// The path runs through 48 register stages: 7 front stages (edges,
// products, cross product, magnitude length, scaling, squares, sum), 25
// square root cells that each settle one root bit, 15 divider cells that
// each settle one quotient bit of all three components, and the output
// register. When the receiver stalls, the whole pipeline holds in
// place and in_ready_o drops; it rises again as soon as the output word
// is taken, so no cycle is lost while the pipeline is full. Reset empties
// the pipeline; nothing is kept between triangles.
// ----------------------------------------------------------------------------
module triangle_unit_normal import tun_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tri_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tri_out_t out_data_o
);

  localparam int SqrtCells = RootW;
  localparam int DivCells  = QuoW;

  logic       en;
  logic       out_valid_q;
  tri_out_t   out_data_q;
  sqrt_word_t sq_w [SqrtCells+1];
  div_word_t  dv_w [DivCells+1];
  tri_out_t   out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tun_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .sq_o       (sq_w[0])
  );

  for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .bit_idx_i (5'(SqrtCells - 1 - g)),
      .word_i    (sq_w[g]),
      .word_o    (sq_w[g+1])
    );
  end

  // The rounded numerator u * 2^14 + root / 2 stays below root * 2^15.
  always_comb begin
    dv_w[0].valid = sq_w[SqrtCells].valid;
    dv_w[0].degen = sq_w[SqrtCells].degen;
    dv_w[0].sign  = sq_w[SqrtCells].sign;
    dv_w[0].root  = sq_w[SqrtCells].root;
    dv_w[0].quo   = '0;
    for (int i = 0; i < 3; i++) begin
      dv_w[0].rem[i] = (NumW'(sq_w[SqrtCells].u[i]) << FracW)
                     + NumW'(sq_w[SqrtCells].root >> 1);
    end
  end

  for (genvar g = 0; g < DivCells; g++) begin : g_div
    tun_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .bit_idx_i (4'(DivCells - 1 - g)),
      .word_i    (dv_w[g]),
      .word_o    (dv_w[g+1])
    );
  end

  always_comb begin
    logic [QuoW-1:0] q [3];
    logic [OutW-1:0] v [3];
    for (int i = 0; i < 3; i++) begin
      q[i] = dv_w[DivCells].quo[i];
      if (q[i] > QuoW'(OneQ14)) q[i] = QuoW'(OneQ14);
      v[i] = dv_w[DivCells].sign[i] ? OutW'(0) - OutW'(q[i]) : OutW'(q[i]);
      if (dv_w[DivCells].degen) v[i] = '0;
    end
    out_d.normal_x   = v[0];
    out_d.normal_y   = v[1];
    out_d.normal_z   = v[2];
    out_d.degenerate = dv_w[DivCells].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_w[DivCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

endmodule

// ===== rtl/core/tun_front.sv =====
// ----------------------------------------------------------------------------
// tun_front
// Edges, cross product, magnitude scaling and sum of squares.
// ----------------------------------------------------------------------------
module tun_front import tun_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       in_valid_i,
  input  tri_in_t    in_data_i,
  output sqrt_word_t sq_o
);

  logic [5:0] vld_q;

  logic signed [EdgeW-1:0] e1_q [3];
  logic signed [EdgeW-1:0] e2_q [3];
  logic signed [ProdW-1:0] p_q  [6];
  logic [2:0][MagW-1:0]    mag_q, mag4_q;
  logic [2:0]              sgn_q, sgn4_q, sgn5_q, sgn6_q;
  logic [LenW-1:0]         len_q;
  logic                    dg4_q, dg5_q, dg6_q;
  logic [2:0][UW-1:0]      u_q, u6_q;
  logic [SqW-1:0]          sqr_q [3];

  logic signed [CrossW-1:0] n_d [3];
  logic [MagW-1:0]          max_d;
  logic [LenW-1:0]          len_d;
  logic [MagW+UW-1:0]       wide_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_comb begin
    n_d[0] = CrossW'(p_q[0]) - CrossW'(p_q[1]);
    n_d[1] = CrossW'(p_q[2]) - CrossW'(p_q[3]);
    n_d[2] = CrossW'(p_q[4]) - CrossW'(p_q[5]);
  end

  always_comb begin
    max_d = mag_q[0];
    if (mag_q[1] > max_d) max_d = mag_q[1];
    if (mag_q[2] > max_d) max_d = mag_q[2];
    len_d = '0;
    for (int b = 0; b < MagW; b++) begin
      if (max_d[b]) len_d = LenW'(b + 1);
    end
  end

  // One shifter covers both directions: left when the length is short,
  // truncating right when it is long.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_d[i] = {mag4_q[i], {UW{1'b0}}} >> len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q[0] <= EdgeW'(in_data_i.b_x) - EdgeW'(in_data_i.a_x);
      e1_q[1] <= EdgeW'(in_data_i.b_y) - EdgeW'(in_data_i.a_y);
      e1_q[2] <= EdgeW'(in_data_i.b_z) - EdgeW'(in_data_i.a_z);
      e2_q[0] <= EdgeW'(in_data_i.c_x) - EdgeW'(in_data_i.b_x);
      e2_q[1] <= EdgeW'(in_data_i.c_y) - EdgeW'(in_data_i.b_y);
      e2_q[2] <= EdgeW'(in_data_i.c_z) - EdgeW'(in_data_i.b_z);

      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];

      for (int i = 0; i < 3; i++) begin
        sgn_q[i] <= n_d[i][CrossW-1];
        mag_q[i] <= n_d[i][CrossW-1] ? MagW'(-n_d[i]) : MagW'(n_d[i]);
      end

      mag4_q <= mag_q;
      sgn4_q <= sgn_q;
      len_q  <= len_d;
      dg4_q  <= (max_d == '0);

      for (int i = 0; i < 3; i++) begin
        u_q[i] <= wide_d[i][UW-1:0];
      end
      sgn5_q <= sgn4_q;
      dg5_q  <= dg4_q;

      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= SqW'(u_q[i]) * SqW'(u_q[i]);
      end
      u6_q   <= u_q;
      sgn6_q <= sgn5_q;
      dg6_q  <= dg5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_o <= '0;
    end else if (en_i) begin
      sq_o.valid <= vld_q[5];
      sq_o.degen <= dg6_q;
      sq_o.sign  <= sgn6_q;
      sq_o.u     <= u6_q;
      sq_o.rem   <= RemW'(sqr_q[0]) + RemW'(sqr_q[1]) + RemW'(sqr_q[2]);
      sq_o.root  <= '0;
    end
  end

endmodule

// ===== rtl/core/tun_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One root bit of the pipelined integer square root.
// ----------------------------------------------------------------------------
module tun_sqrt_cell import tun_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [4:0] bit_idx_i,
  input  sqrt_word_t word_i,
  output sqrt_word_t word_o
);

  logic [RemW-1:0] trial;
  sqrt_word_t      word_d;

  // The trial is 2*root*2^k + 4^k, the growth of root^2 when bit k is set.
  always_comb begin
    trial  = (RemW'(word_i.root) << (bit_idx_i + 5'd1))
           + (RemW'(1) << {bit_idx_i, 1'b0});
    word_d = word_i;
    if (word_i.rem >= trial) begin
      word_d.rem  = word_i.rem - trial;
      word_d.root = word_i.root | (RootW'(1) << bit_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_o <= '0;
    end else if (en_i) begin
      word_o <= word_d;
    end
  end

endmodule

// ===== rtl/core/tun_div_cell.sv =====
// ----------------------------------------------------------------------------
// tun_div_cell
// One quotient bit of the three restoring dividers.
// ----------------------------------------------------------------------------
module tun_div_cell import tun_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [3:0] bit_idx_i,
  input  div_word_t  word_i,
  output div_word_t  word_o
);

  logic [NumW-1:0] dvs;
  div_word_t       word_d;

  always_comb begin
    dvs    = NumW'(word_i.root) << bit_idx_i;
    word_d = word_i;
    for (int i = 0; i < 3; i++) begin
      if (word_i.rem[i] >= dvs) begin
        word_d.rem[i] = word_i.rem[i] - dvs;
        word_d.quo[i] = word_i.quo[i] | (QuoW'(1) << bit_idx_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_o <= '0;
    end else if (en_i) begin
      word_o <= word_d;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives triangles into triangle_unit_normal and compares every output word
// against a predicted unit normal, under several idling and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import tun_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  tri_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tri_out_t out_data_o;

  triangle_unit_normal dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tri_out_t normal_q[$];
  int       mismatch_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_cycles = 0;

  function automatic tri_out_t unit_normal(tri_in_t t);
    longint      e1[3], e2[3], n[3];
    longint      m, s2, r, q, v, bit_w, rr;
    longint      u[3];
    int          len;
    tri_out_t    o;
    logic [15:0] comp[3];
    e1[0] = longint'(t.b_x) - longint'(t.a_x);
    e1[1] = longint'(t.b_y) - longint'(t.a_y);
    e1[2] = longint'(t.b_z) - longint'(t.a_z);
    e2[0] = longint'(t.c_x) - longint'(t.b_x);
    e2[1] = longint'(t.c_y) - longint'(t.b_y);
    e2[2] = longint'(t.c_z) - longint'(t.b_z);
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = n[i] < 0 ? -n[i] : n[i];
      if (u[i] > m) m = u[i];
    end
    o = '0;
    if (m == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    len = 0;
    v = m;
    while (v != 0) begin
      len++;
      v = v >> 1;
    end
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > 24) u[i] = u[i] >> (len - 24);
      else u[i] = u[i] << (24 - len);
      s2 += u[i] * u[i];
    end
    // Bitwise integer square root; s2 stays below 2^50.
    rr = 0;
    bit_w = 64'sd1 << 60;
    v = s2;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= rr + bit_w) begin
        v = v - (rr + bit_w);
        rr = (rr >> 1) + bit_w;
      end else begin
        rr = rr >> 1;
      end
      bit_w = bit_w >> 2;
    end
    r = rr;
    for (int i = 0; i < 3; i++) begin
      q = (u[i] * OneQ14 + (r >> 1)) / r;
      if (q > OneQ14) q = OneQ14;
      comp[i] = n[i] < 0 ? 16'(-q) : 16'(q);
    end
    o.normal_x = comp[0];
    o.normal_y = comp[1];
    o.normal_z = comp[2];
    return o;
  endfunction

  task automatic report_mismatch(string what, tri_out_t got, tri_out_t want);
    $display("mismatch %s: got %0d %0d %0d %0b want %0d %0d %0d %0b", what,
             got.normal_x, got.normal_y, got.normal_z, got.degenerate,
             want.normal_x, want.normal_y, want.normal_z, want.degenerate);
    mismatch_cnt++;
  endtask

  // Receiver: random stall, plus a long hold-off when hold_cycles is set.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tri_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (normal_q.size() == 0) begin
        report_mismatch("unexpected word", out_data_o, '0);
      end else begin
        want = normal_q.pop_front();
        if (out_data_o.normal_x !== want.normal_x)
          report_mismatch("normal_x", out_data_o, want);
        if (out_data_o.normal_y !== want.normal_y)
          report_mismatch("normal_y", out_data_o, want);
        if (out_data_o.normal_z !== want.normal_z)
          report_mismatch("normal_z", out_data_o, want);
        if (out_data_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", out_data_o, want);
      end
    end
  end

  // Valid stays high from one word to the next unless the sender idles.
  task automatic send_triangle(tri_in_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    normal_q.push_back(unit_normal(t));
  endtask

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(5))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return 20'(signed'($urandom_range(64)) - 32);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic tri_in_t rand_triangle();
    tri_in_t t;
    t = '0;
    for (int i = 0; i < 9; i++) t[i*20 +: 20] = rand_coord();
    case ($urandom_range(9))
      0: begin
        t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
      end
      1: begin
        // Collinear: c continues the a-b edge.
        t.c_x = t.b_x + (t.b_x - t.a_x);
        t.c_y = t.b_y + (t.b_y - t.a_y);
        t.c_z = t.b_z + (t.b_z - t.a_z);
      end
      2: begin
        // Edge a-b almost level in z: b_z lies within one of a_z.
        t.c_z = t.b_z;
        t.b_z = t.a_z + 20'($urandom_range(1));
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    tri_in_t t;
    t = '0;
    send_triangle(t);
    t = '0; t.b_x = 20'd1024; t.c_x = 20'd1024; t.c_y = 20'd1024;
    send_triangle(t);
    t = '0; t.b_y = 20'd1024; t.c_y = 20'd1024; t.c_z = 20'd1024;
    send_triangle(t);
    t = '0; t.b_z = 20'd1024; t.c_z = 20'd1024; t.c_x = 20'd1024;
    send_triangle(t);
    t = '0; t.b_x = 20'd1; t.c_x = 20'd1; t.c_y = 20'd1;
    send_triangle(t);
    t = {9{20'h80000}};
    send_triangle(t);
    t = {9{20'h7FFFF}};
    send_triangle(t);
    t = '0; t.a_x = 20'h80000; t.a_y = 20'h80000; t.b_x = 20'h7FFFF;
    t.b_y = 20'h80000; t.c_x = 20'h7FFFF; t.c_y = 20'h7FFFF; t.c_z = 20'h7FFFF;
    send_triangle(t);
    t = '0; t.a_x = 20'h7FFFF; t.b_y = 20'h80000; t.c_z = 20'h7FFFF;
    send_triangle(t);
    t = '0; t.a_x = 20'h80000; t.b_y = 20'h7FFFF; t.c_z = 20'h80000;
    send_triangle(t);
    // Tiny component next to a large one.
    t = '0; t.b_x = 20'h7FFFF; t.c_x = 20'h7FFFF; t.c_y = 20'h7FFFF; t.c_z = 20'd1;
    send_triangle(t);
    // Collinear points.
    t = '0; t.b_x = 20'd5; t.b_y = 20'd7; t.c_x = 20'd10; t.c_y = 20'd14;
    send_triangle(t);
    t = '0; t.a_x = 20'hFFFFF; t.b_y = 20'hFFFFF; t.c_z = 20'hFFFFF;
    send_triangle(t);
    for (int i = 0; i < 8; i++) send_triangle(rand_triangle());
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_triangle(rand_triangle());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    hold_cycles <= 200;
    for (int i = 0; i < 80; i++) send_triangle(rand_triangle());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120, 0, 0);
    test_random(120, 53, 0);
    test_random(120, 0, 53);
    test_random(120, 17, 17);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && normal_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== triangle_unit_normal.f =====
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_sqrt_cell.sv
rtl/core/tun_div_cell.sv
rtl/core/triangle_unit_normal.sv
tb/testbench.sv
